FILE: hw/rtl/qte_pkg.sv
// Shared widths, payload types and constant tables of the quaternion to Euler unit.
`timescale 1ns / 1ps
package qte_pkg;

  localparam int IN_W         = 16;
  localparam int YAW_W        = 16;
  localparam int PITCH_W      = 15;
  localparam int ROLL_W       = 16;
  localparam int PROD_W       = 32;
  localparam int TERM_W       = 34;
  localparam int SIN_W        = 30;
  localparam int ROOT_W       = 29;
  localparam int SQN_W        = 57;
  localparam int SQR_W        = 58;
  localparam int NRM_W        = 36;
  localparam int CRD_W        = 38;
  localparam int ANG_W        = 34;
  localparam int QOUT_W       = 17;

  localparam int SQRT_STEPS   = 29;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 30;
  localparam int LANES        = 3;
  localparam int LATENCY      = 3 + SQRT_STEPS + NORM_STEPS + 1 + CORDIC_STEPS + 1;

  localparam int LANE_YAW     = 0;
  localparam int LANE_PITCH   = 1;
  localparam int LANE_ROLL    = 2;

  localparam logic signed [TERM_W-1:0] ONE_Q28     = TERM_W'(1) <<< 28;
  localparam logic [SQN_W-1:0]         ONE_Q56     = SQN_W'(1) << 56;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = ANG_W'(1686629713);
  localparam logic signed [ANG_W-1:0]  ROUND_Q17   = ANG_W'(65536);
  localparam logic signed [QOUT_W-1:0] PI_Q13      = QOUT_W'(25736);
  localparam logic signed [QOUT_W-1:0] HALF_PI_Q13 = QOUT_W'(12868);

  localparam logic signed [ANG_W-1:0] ATAN_TAB [0:10] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576
  };

  typedef struct packed {
    logic signed [TERM_W-1:0] ya;
    logic signed [TERM_W-1:0] yb;
    logic signed [TERM_W-1:0] ra;
    logic signed [TERM_W-1:0] rb;
    logic signed [SIN_W-1:0]  s;
  } term_t;

  typedef struct packed {
    logic [SQN_W-1:0] n;
    logic [SQR_W-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] a;
    logic signed [NRM_W-1:0] b;
  } vec_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } cordic_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ANG_W-1:0] atan_ang(input int i);
    logic signed [ANG_W-1:0] r;
    if (i <= 10) begin
      r = ATAN_TAB[i[3:0]];
    end else begin
      r = ANG_W'(1) <<< (30 - i);
    end
    return r;
  endfunction

  // normalize schedule: shift amount and magnitude limit of step k
  function automatic int norm_sh(input int k);
    int r;
    case (k)
      0:       r = 16;
      1:       r = 8;
      2:       r = 4;
      3:       r = 2;
      default: r = 1;
    endcase
    return r;
  endfunction

  function automatic int norm_lim(input int k);
    int r;
    case (k)
      0:       r = 16;
      1:       r = 24;
      2:       r = 28;
      3:       r = 30;
      4:       r = 31;
      default: r = 32;
    endcase
    return r;
  endfunction

  function automatic logic [NRM_W-1:0] mag_nrm(input logic signed [NRM_W-1:0] v);
    return v[NRM_W-1] ? NRM_W'(-v) : NRM_W'(v);
  endfunction

endpackage

FILE: hw/rtl/qte_in_if.sv
// Input channel: one quaternion per transaction.
`timescale 1ns / 1ps
interface qte_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [qte_pkg::IN_W-1:0]   q_w;
  logic signed [qte_pkg::IN_W-1:0]   q_x;
  logic signed [qte_pkg::IN_W-1:0]   q_y;
  logic signed [qte_pkg::IN_W-1:0]   q_z;

  modport source (output valid, output q_w, output q_x, output q_y, output q_z,
                  input ready);
  modport sink (input valid, input q_w, input q_x, input q_y, input q_z,
                output ready);
endinterface

FILE: hw/rtl/qte_out_if.sv
// Result channel: yaw, pitch and roll per transaction.
`timescale 1ns / 1ps
interface qte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qte_pkg::YAW_W-1:0]   yaw_angle;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_angle;

  modport source (output valid, output yaw_angle, output pitch_angle,
                  output roll_angle, input ready);
  modport sink (input valid, input yaw_angle, input pitch_angle,
                input roll_angle, output ready);
endinterface

FILE: hw/rtl/qte_sqrt_cell.sv
// One digit step of the restoring integer square root.
`timescale 1ns / 1ps
module qte_sqrt_cell #(
  parameter int BIT_POS = 56
) (
  input  logic            clk,
  input  logic            en,
  input  qte_pkg::sqrt_t  d_in,
  output qte_pkg::sqrt_t  d_out
);
  localparam int RW = qte_pkg::SQR_W;
  localparam int NW = qte_pkg::SQN_W;
  localparam logic [RW-1:0] BIT_V = RW'(1) << BIT_POS;

  logic [RW-1:0]  trial;
  qte_pkg::sqrt_t q_nxt, q_r;

  always_comb begin
    trial = d_in.r + BIT_V;
    if ({1'b0, d_in.n} >= trial) begin
      q_nxt.n = d_in.n - trial[NW-1:0];
      q_nxt.r = (d_in.r >> 1) + BIT_V;
    end else begin
      q_nxt.n = d_in.n;
      q_nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

FILE: hw/rtl/qte_norm_cell.sv
// One step of the binary normalizing shift: both operands move left together.
`timescale 1ns / 1ps
module qte_norm_cell #(
  parameter int SH  = 16,
  parameter int LIM = 16
) (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::vec_t  d_in,
  output qte_pkg::vec_t  d_out
);
  localparam int W = qte_pkg::NRM_W;
  localparam logic [W-1:0] LIM_V = W'(1) << LIM;

  logic          fits;
  qte_pkg::vec_t q_nxt, q_r;

  always_comb begin
    fits = (qte_pkg::mag_nrm(d_in.a) < LIM_V) && (qte_pkg::mag_nrm(d_in.b) < LIM_V);
    q_nxt = d_in;
    if (fits) begin
      q_nxt.a = d_in.a <<< SH;
      q_nxt.b = d_in.b <<< SH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

FILE: hw/rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation.
`timescale 1ns / 1ps
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  qte_pkg::cordic_t d_in,
  output qte_pkg::cordic_t d_out
);
  localparam logic signed [qte_pkg::ANG_W-1:0] ANG = qte_pkg::atan_ang(STEP);

  logic signed [qte_pkg::CRD_W-1:0] x, y, xs, ys;
  qte_pkg::cordic_t q_nxt, q_r;

  always_comb begin
    x  = d_in.x;
    y  = d_in.y;
    xs = x >>> STEP;
    ys = y >>> STEP;
    q_nxt = d_in;
    if (y > 0) begin
      q_nxt.x = x + ys;
      q_nxt.y = y - xs;
      q_nxt.z = d_in.z + ANG;
    end else begin
      q_nxt.x = x - ys;
      q_nxt.y = y + xs;
      q_nxt.z = d_in.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

FILE: hw/rtl/quaternion_to_euler_angles_unit.sv
// Top level: quaternion (Q2.14) to Z-Y-X Euler angles (Q3.13/Q2.13 radians).
`timescale 1ns / 1ps
// Converts one orientation quaternion (w,x,y,z, signed Q2.14) per transaction
// into yaw and roll (signed Q3.13) and pitch (signed Q2.13) in radians. Yaw
// and roll are atan2(2(wz+xy), 2(w^2+x^2)-1) and atan2(2(wx+yz),
// 2(w^2+z^2)-1); pitch is asin(-2(xz-wy)) taken as atan2(s, sqrt(1-s^2))
// with s saturated to +-1. Non-unit inputs are processed by the same
// formulas. The unit is a fully pipelined row of cells: 3 front stages
// (products, sums, square), 29 square root cells, 6 normalize cells, a
// quadrant fold, 30 CORDIC cells and the output register. The whole row
// advances whenever the output register is empty or being taken, so
// in_if.ready drops only while a result waits and the consumer is stalling;
// otherwise throughput is one transaction per cycle.
module quaternion_to_euler_angles_unit (
  input  logic       clk,
  input  logic       rst_n,
  qte_in_if.sink     in_if,
  qte_out_if.source  out_if
);
  localparam int LAT = qte_pkg::LATENCY;
  localparam int NS  = qte_pkg::SQRT_STEPS;
  localparam int NN  = qte_pkg::NORM_STEPS;
  localparam int NC  = qte_pkg::CORDIC_STEPS;
  localparam int NL  = qte_pkg::LANES;
  localparam int PW  = qte_pkg::PROD_W;
  localparam int TW  = qte_pkg::TERM_W;
  localparam int SW  = qte_pkg::SIN_W;
  localparam int NW  = qte_pkg::NRM_W;
  localparam int CW  = qte_pkg::CRD_W;
  localparam int AW  = qte_pkg::ANG_W;
  localparam int OW  = qte_pkg::QOUT_W;

  // pipeline advance
  logic           en;
  logic [LAT-1:0] v_r;

  assign en          = !v_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_if.valid};
    end
  end

  // stage 1: the nine products
  logic signed [PW-1:0] p_ww_r, p_xx_r, p_zz_r, p_wz_r, p_xy_r, p_wx_r, p_yz_r,
                        p_xz_r, p_wy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww_r <= in_if.q_w * in_if.q_w;
      p_xx_r <= in_if.q_x * in_if.q_x;
      p_zz_r <= in_if.q_z * in_if.q_z;
      p_wz_r <= in_if.q_w * in_if.q_z;
      p_xy_r <= in_if.q_x * in_if.q_y;
      p_wx_r <= in_if.q_w * in_if.q_x;
      p_yz_r <= in_if.q_y * in_if.q_z;
      p_xz_r <= in_if.q_x * in_if.q_z;
      p_wy_r <= in_if.q_w * in_if.q_y;
    end
  end

  // stage 2: argument terms, arcsine argument saturated to +-1 (Q28)
  qte_pkg::term_t      term_nxt, term_r;
  logic signed [TW-1:0] s_full;

  always_comb begin
    term_nxt.ya = (TW'(p_wz_r) + TW'(p_xy_r)) <<< 1;
    term_nxt.yb = ((TW'(p_ww_r) + TW'(p_xx_r)) <<< 1) - qte_pkg::ONE_Q28;
    term_nxt.ra = (TW'(p_wx_r) + TW'(p_yz_r)) <<< 1;
    term_nxt.rb = ((TW'(p_ww_r) + TW'(p_zz_r)) <<< 1) - qte_pkg::ONE_Q28;
    s_full      = -((TW'(p_xz_r) - TW'(p_wy_r)) <<< 1);
    if (s_full > qte_pkg::ONE_Q28) begin
      term_nxt.s = SW'(qte_pkg::ONE_Q28);
    end else if (s_full < -qte_pkg::ONE_Q28) begin
      term_nxt.s = SW'(-qte_pkg::ONE_Q28);
    end else begin
      term_nxt.s = SW'(s_full);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

  // stage 3: radicand 1 - s^2 in Q56; terms enter the delay line
  logic signed [SW-1:0]   s_v;
  logic signed [2*SW-1:0] s_sq;
  qte_pkg::sqrt_t         sq0_nxt;
  qte_pkg::sqrt_t         sv [NS+1];
  qte_pkg::term_t         dl_r [NS+1];

  always_comb begin
    s_v       = term_r.s;
    s_sq      = s_v * s_v;
    sq0_nxt.n = qte_pkg::ONE_Q56 - s_sq[qte_pkg::SQN_W-1:0];
    sq0_nxt.r = '0;
  end

  qte_pkg::sqrt_t sq0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r    <= sq0_nxt;
      dl_r[0]  <= term_r;
    end
  end
  assign sv[0] = sq0_r;

  // square root cells, terms ride alongside in a shift line
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT_POS(56 - 2 * k)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (sv[k]),
      .d_out(sv[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[k+1] <= dl_r[k];
      end
    end
  end

  // lane operands (a = numerator, b = denominator)
  qte_pkg::vec_t lane_in [NL];
  always_comb begin
    lane_in[qte_pkg::LANE_YAW].a   = NW'(dl_r[NS].ya);
    lane_in[qte_pkg::LANE_YAW].b   = NW'(dl_r[NS].yb);
    lane_in[qte_pkg::LANE_PITCH].a = NW'(dl_r[NS].s);
    lane_in[qte_pkg::LANE_PITCH].b = NW'({1'b0, sv[NS].r[qte_pkg::ROOT_W-1:0]});
    lane_in[qte_pkg::LANE_ROLL].a  = NW'(dl_r[NS].ra);
    lane_in[qte_pkg::LANE_ROLL].b  = NW'(dl_r[NS].rb);
  end

  qte_pkg::cordic_t lane_out [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    qte_pkg::vec_t    nv [NN+1];
    qte_pkg::cordic_t cv [NC+1];
    qte_pkg::cordic_t fold_nxt, fold_r;

    assign nv[0] = lane_in[l];

    // normalize until the larger magnitude reaches 2^32
    for (genvar k = 0; k < NN; k++) begin : g_norm
      qte_norm_cell #(
        .SH (qte_pkg::norm_sh(k)),
        .LIM(qte_pkg::norm_lim(k))
      ) u_cell (
        .clk  (clk),
        .en   (en),
        .d_in (nv[k]),
        .d_out(nv[k+1])
      );
    end

    // fold left half-plane into the right one, note the zero vector
    always_comb begin
      fold_nxt.zero = (nv[NN].a == '0) && (nv[NN].b == '0);
      if (nv[NN].b < 0) begin
        if (nv[NN].a >= 0) begin
          fold_nxt.x = CW'(nv[NN].a);
          fold_nxt.y = -CW'(nv[NN].b);
          fold_nxt.z = qte_pkg::HALF_PI_Q30;
        end else begin
          fold_nxt.x = -CW'(nv[NN].a);
          fold_nxt.y = CW'(nv[NN].b);
          fold_nxt.z = -qte_pkg::HALF_PI_Q30;
        end
      end else begin
        fold_nxt.x = CW'(nv[NN].b);
        fold_nxt.y = CW'(nv[NN].a);
        fold_nxt.z = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fold_r <= fold_nxt;
      end
    end
    assign cv[0] = fold_r;

    for (genvar k = 0; k < NC; k++) begin : g_cordic
      qte_cordic_cell #(.STEP(k)) u_cell (
        .clk  (clk),
        .en   (en),
        .d_in (cv[k]),
        .d_out(cv[k+1])
      );
    end

    assign lane_out[l] = cv[NC];
  end

  // Q30 angle to Q13: round toward minus infinity after adding half, then clamp
  function automatic logic signed [OW-1:0] to_q13(input qte_pkg::cordic_t c,
                                                  input logic signed [OW-1:0] lim);
    logic signed [AW-1:0] zr;
    logic signed [OW-1:0] q;
    zr = c.z + qte_pkg::ROUND_Q17;
    q  = zr[AW-1:AW-OW];
    if (c.zero) begin
      q = '0;
    end else if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

  logic signed [OW-1:0] yaw_q, pitch_q, roll_q;
  always_comb begin
    yaw_q   = to_q13(lane_out[qte_pkg::LANE_YAW], qte_pkg::PI_Q13);
    pitch_q = to_q13(lane_out[qte_pkg::LANE_PITCH], qte_pkg::HALF_PI_Q13);
    roll_q  = to_q13(lane_out[qte_pkg::LANE_ROLL], qte_pkg::PI_Q13);
  end

  // output register
  logic signed [qte_pkg::YAW_W-1:0]   yaw_r;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_r;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= qte_pkg::YAW_W'(yaw_q);
      pitch_r <= qte_pkg::PITCH_W'(pitch_q);
      roll_r  <= qte_pkg::ROLL_W'(roll_q);
    end
  end

  assign out_if.valid       = v_r[LAT-1];
  assign out_if.yaw_angle   = yaw_r;
  assign out_if.pitch_angle = pitch_r;
  assign out_if.roll_angle  = roll_r;
endmodule

FILE: tb/sv/testbench.sv
// Testbench of the quaternion to Euler angles unit, checked against a built-in predictor.
`timescale 1ns / 1ps
// Drives quaternions into the unit over the input channel. Each accepted
// transaction is run through a bit-exact predictor of the fixed-point datapath:
//   - Q28 product sums
//   - a 30-step vectoring CORDIC atan2
//   - pitch taken as atan2(s, sqrt(1 - s^2)) with s saturated
// The predicted angles are queued. A monitor takes each result transaction off
// the output channel and compares it field by field with the oldest queued
// prediction.
//
// Stimulus:
//   - a directed set: identity, zero vector, extremes, axis flips, gimbal lock
//     and saturated arcsine
//   - random unit quaternions, some of them near gimbal lock
//   - raw 16-bit noise
//   - a stretch with no idling on either side
//
// Handshakes are sampled on the falling edge. Inputs only change at the rising
// edge, so the sampled values are stable.
module testbench;

  typedef struct packed {
    logic signed [qte_pkg::YAW_W-1:0]   yaw;
    logic signed [qte_pkg::PITCH_W-1:0] pitch;
    logic signed [qte_pkg::ROLL_W-1:0]  roll;
  } euler_t;

  localparam longint Q28_ONE = 64'sd1 << 28;

  logic clk = 1'b0;
  logic rst_n;

  qte_in_if  in_if ();
  qte_out_if out_if ();

  quaternion_to_euler_angles_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #4 clk = ~clk;

  euler_t angle_q[$];
  int     mismatches = 0;
  bit     idle_en    = 1'b1;   // random idling on both sides when set

  // ---------------------------------------------------------------- predictor
  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // atan(2^-i) in Q30; exact powers of two past step 10
  function automatic longint atan_step(int i);
    longint tab [0:10];
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576};
    return (i <= 10) ? tab[i] : (64'sd1 <<< (30 - i));
  endfunction

  // vectoring CORDIC atan2(a, b), Q30 radians
  function automatic longint atan2_q30(longint a, longint b);
    longint xv, yv, zv, t, xs, ys;
    xv = b;
    yv = a;
    zv = 0;
    if (xv == 0 && yv == 0) begin
      return 0;
    end
    // normalize both terms up together so the magnitudes sit at 2^32
    while (abs64(xv) < (64'sd1 <<< 32) && abs64(yv) < (64'sd1 <<< 32)) begin
      xv = xv * 2;
      yv = yv * 2;
    end
    // quadrant fold into the right half plane
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        zv = 1686629713;
      end else begin
        xv = -yv;
        yv = t;
        zv = -1686629713;
      end
    end
    for (int i = 0; i < 30; i++) begin
      xs = xv >>> i;       // arithmetic shift: rounds toward minus infinity
      ys = yv >>> i;
      if (yv > 0) begin
        xv = xv + ys;
        yv = yv - xs;
        zv = zv + atan_step(i);
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zv = zv - atan_step(i);
      end
    end
    return zv;
  endfunction

  function automatic longint q30_to_q13(longint zv, longint lim);
    longint r;
    r = (zv + (64'sd1 <<< 16)) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // truncating integer square root
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic euler_t predict_euler(logic signed [qte_pkg::IN_W-1:0] qw,
                                          logic signed [qte_pkg::IN_W-1:0] qx,
                                          logic signed [qte_pkg::IN_W-1:0] qy,
                                          logic signed [qte_pkg::IN_W-1:0] qz);
    longint w, x, y, z, ya, yb, ra, rb, s, c;
    euler_t e;
    w  = longint'(qw);
    x  = longint'(qx);
    y  = longint'(qy);
    z  = longint'(qz);
    ya = 2 * (w * z + x * y);
    yb = 2 * (w * w + x * x) - Q28_ONE;
    ra = 2 * (w * x + y * z);
    rb = 2 * (w * w + z * z) - Q28_ONE;
    s  = -2 * (x * z - w * y);
    if (s > Q28_ONE) s = Q28_ONE;       // arcsine argument saturates at +-1
    if (s < -Q28_ONE) s = -Q28_ONE;
    c  = longint'(root64((64'd1 << 56) - longint'(s * s)));
    e.yaw   = qte_pkg::YAW_W'(q30_to_q13(atan2_q30(ya, yb), 64'sd25736));
    e.pitch = qte_pkg::PITCH_W'(q30_to_q13(atan2_q30(s, c), 64'sd12868));
    e.roll  = qte_pkg::ROLL_W'(q30_to_q13(atan2_q30(ra, rb), 64'sd25736));
    return e;
  endfunction

  // ---------------------------------------------------------------- drivers
  // one quaternion transaction, with random idle cycles ahead of it when idle_en is set
  task automatic send_quat(logic signed [qte_pkg::IN_W-1:0] qw,
                           logic signed [qte_pkg::IN_W-1:0] qx,
                           logic signed [qte_pkg::IN_W-1:0] qy,
                           logic signed [qte_pkg::IN_W-1:0] qz);
    bit taken;
    while (idle_en && $urandom_range(0, 99) < 20) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.q_w   <= qw;
    in_if.q_x   <= qx;
    in_if.q_y   <= qy;
    in_if.q_z   <= qz;
    do begin
      @(negedge clk);
      taken = in_if.ready;
      if (taken) angle_q.push_back(predict_euler(qw, qx, qy, qz));
      @(posedge clk);
    end while (!taken);
  endtask

  // consumer stalls
  always @(posedge clk) begin
    if (rst_n) begin
      out_if.ready <= !(idle_en && $urandom_range(0, 99) < 20);
    end
  end

  // result monitor
  always @(negedge clk) begin
    euler_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        want = angle_q.pop_front();
        if (out_if.yaw_angle !== want.yaw || out_if.pitch_angle !== want.pitch ||
            out_if.roll_angle !== want.roll) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: yaw %0d/%0d pitch %0d/%0d roll %0d/%0d (exp/act)",
                     $realtime, want.yaw, out_if.yaw_angle, want.pitch,
                     out_if.pitch_angle, want.roll, out_if.roll_angle);
          end
        end
      end
    end
  end

  // random unit quaternion; with near_lock set, near pitch +pi/2 unless y is flipped
  task automatic send_unit_quat(bit near_lock);
    real    c [4];
    real    nrm;
    integer v [4];
    if (near_lock) begin
      // w = y and x = -z give s = +1; small noise keeps it near the edge
      c[0] = $urandom_range(0, 2000) - 1000.0;
      c[2] = c[0] + ($urandom_range(0, 40) - 20.0);
      c[1] = $urandom_range(0, 2000) - 1000.0;
      c[3] = -c[1] + ($urandom_range(0, 40) - 20.0);
      if ($urandom_range(0, 1)) c[2] = -c[2];
    end else begin
      foreach (c[i]) c[i] = $urandom_range(0, 65535) - 32768.0;
    end
    nrm = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
    if (nrm == 0.0) nrm = 1.0;
    foreach (v[i]) v[i] = $rtoi(c[i] * 16384.0 / nrm + (c[i] < 0 ? -0.5 : 0.5));
    send_quat(qte_pkg::IN_W'(v[0]), qte_pkg::IN_W'(v[1]),
              qte_pkg::IN_W'(v[2]), qte_pkg::IN_W'(v[3]));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_quat(16384, 0, 0, 0);              // identity
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);                  // zero vector, both denominators -1
    send_quat(0, 16384, 0, 0);              // roll of pi
    send_quat(0, 0, 16384, 0);              // yaw and roll on the negative axis
    send_quat(0, 0, 0, 16384);              // yaw of pi
    send_quat(11585, 0, 0, 11585);          // yaw +pi/2
    send_quat(11585, 0, 0, -11585);         // yaw -pi/2
    send_quat(11585, 11585, 0, 0);          // roll +pi/2
    send_quat(11585, 0, 11585, 0);          // pitch +pi/2
    send_quat(11585, 0, -11585, 0);         // pitch -pi/2
    send_quat(8192, 8192, 8192, -8192);     // gimbal lock, s = +1
    send_quat(8192, -8192, -8192, -8192);   // gimbal lock, s = -1
    send_quat(16384, 0, 16384, 0);          // arcsine argument beyond +1
    send_quat(16384, 16384, 0, 16384);      // arcsine argument beyond -1
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, -32768, 32767, -32768);
    send_quat(0, 0, 0, -32768);
    send_quat(16384, 16384, 16384, 16384);  // non-unit
    send_quat(1, 0, 0, 0);
    send_quat(0, -1, 1, 0);
  endtask

  task automatic test_unit_random(int n);
    repeat (n) send_unit_quat($urandom_range(0, 9) == 0);
  endtask

  task automatic test_raw_random(int n);
    repeat (n) begin
      send_quat(qte_pkg::IN_W'($urandom), qte_pkg::IN_W'($urandom),
                qte_pkg::IN_W'($urandom), qte_pkg::IN_W'($urandom));
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_en = 1'b0;
    repeat (n) send_unit_quat(1'b0);
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.q_w    = '0;
    in_if.q_x    = '0;
    in_if.q_y    = '0;
    in_if.q_z    = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_unit_random(1100);
    test_back_to_back(200);
    test_raw_random(400);
    in_if.valid <= 1'b0;

    // drain the pipeline, then let the latency pass for stray results
    while (angle_q.size() != 0) @(posedge clk);
    repeat (qte_pkg::LATENCY + 20) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
